/* hw/rtl/double_ended_queue_defines.svh */
// Assertion macros for the double-ended queue checker.
// Depends on nothing; expects clk_i and rst_ni in the scope of each use.
`ifndef DOUBLE_ENDED_QUEUE_DEFINES_SVH
`define DOUBLE_ENDED_QUEUE_DEFINES_SVH

// Check a property on every rising clock edge outside reset.
`define DEQ_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Check that an antecedent is followed by a consequent in the next cycle.
`define DEQ_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* hw/rtl/deq_pkg.sv */
// Package for the double-ended queue: sizes, action and status codes,
// word structs and the wrap-around index helper. No dependencies.
package deq_pkg;

  localparam int unsigned Depth    = 16;
  localparam int unsigned DataW    = 32;
  localparam int unsigned ItemW    = 32;
  localparam int unsigned PtrW     = $clog2(Depth);
  localparam int unsigned CntW     = $clog2(Depth + 1);

  typedef enum logic [2:0] {
    ActPushFront = 3'd0,
    ActPushBack  = 3'd1,
    ActPopFront  = 3'd2,
    ActPopBack   = 3'd3,
    ActPeekFront = 3'd4,
    ActPeekBack  = 3'd5,
    ActClear     = 3'd6
  } deq_action_e;

  typedef enum logic [1:0] {
    StsOk    = 2'd0,
    StsEmpty = 2'd1,
    StsFull  = 2'd2
  } deq_status_e;

  typedef struct packed {
    deq_action_e       action;
    logic [ItemW-1:0]  push_data;
  } deq_in_t;

  typedef struct packed {
    deq_status_e       status;
    logic [ItemW-1:0]  read_data;
  } deq_out_t;

  typedef struct packed {
    logic              wr_en;
    logic              rd_en;
    logic [PtrW-1:0]   addr;
    logic [DataW-1:0]  wdata;
  } deq_mem_req_t;

  typedef struct packed {
    logic              valid;
    deq_status_e       status;
    logic              rd_sel;
  } deq_rsp_t;

  // (base + off) modulo Depth, for base < Depth and off <= Depth
  function automatic logic [PtrW-1:0] wrap_add(logic [PtrW-1:0] base, logic [CntW-1:0] off);
    logic [CntW:0] sum;
    sum = (CntW+1)'(base) + (CntW+1)'(off);
    if (sum >= (CntW+1)'(Depth)) begin
      sum = sum - (CntW+1)'(Depth);
    end
    return sum[PtrW-1:0];
  endfunction

endpackage

/* hw/rtl/deq_ram.sv */
// Single-port synchronous RAM with registered read data.
// Generic; no package dependencies.
module deq_ram #(
  parameter int unsigned Depth = 16,
  parameter int unsigned Width = 32
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] addr_i,
  input  logic [Width-1:0]         wdata_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  // write one word, and/or read one word into the registered read data
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[addr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

/* hw/rtl/deq_ctrl.sv */
// Pointer and count control for the double-ended queue: decodes the action,
// drives the RAM port and registers the result status. Uses deq_pkg.
module deq_ctrl (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      accept_i,
  input  deq_pkg::deq_in_t          item_i,
  output deq_pkg::deq_mem_req_t     mem_req_o,
  output deq_pkg::deq_rsp_t         rsp_o
);

  logic [deq_pkg::PtrW-1:0] head_q, head_d;
  logic [deq_pkg::CntW-1:0] count_q, count_d;
  deq_pkg::deq_rsp_t        rsp_q, rsp_d;
  deq_pkg::deq_mem_req_t    req;

  logic                     full, empty;
  logic [deq_pkg::PtrW-1:0] head_dec, head_inc, back_idx, last_idx;

  // derive full, empty and neighbor indexes of the front and back
  assign full     = (count_q == deq_pkg::CntW'(deq_pkg::Depth));
  assign empty    = (count_q == '0);
  assign head_dec = (head_q == '0) ? deq_pkg::PtrW'(deq_pkg::Depth - 1)
                                   : head_q - deq_pkg::PtrW'(1);
  assign head_inc = deq_pkg::wrap_add(head_q, deq_pkg::CntW'(1));
  assign back_idx = deq_pkg::wrap_add(head_q, count_q);
  assign last_idx = deq_pkg::wrap_add(head_q, count_q - deq_pkg::CntW'(1));

  // decode the action into a RAM access and the next pointer state
  always_comb begin
    head_d       = head_q;
    count_d      = count_q;
    req          = '0;
    req.wdata    = deq_pkg::DataW'(item_i.push_data);
    rsp_d.valid  = accept_i;
    rsp_d.status = deq_pkg::StsOk;
    rsp_d.rd_sel = 1'b0;
    if (accept_i) begin
      unique case (item_i.action)
        deq_pkg::ActPushFront: begin
          if (full) begin
            rsp_d.status = deq_pkg::StsFull;
          end else begin
            head_d    = head_dec;
            count_d   = count_q + deq_pkg::CntW'(1);
            req.wr_en = 1'b1;
            req.addr  = head_dec;
          end
        end
        deq_pkg::ActPushBack: begin
          if (full) begin
            rsp_d.status = deq_pkg::StsFull;
          end else begin
            count_d   = count_q + deq_pkg::CntW'(1);
            req.wr_en = 1'b1;
            req.addr  = back_idx;
          end
        end
        deq_pkg::ActPopFront, deq_pkg::ActPeekFront: begin
          if (empty) begin
            rsp_d.status = deq_pkg::StsEmpty;
          end else begin
            req.rd_en    = 1'b1;
            req.addr     = head_q;
            rsp_d.rd_sel = 1'b1;
            if (item_i.action == deq_pkg::ActPopFront) begin
              head_d  = head_inc;
              count_d = count_q - deq_pkg::CntW'(1);
            end
          end
        end
        deq_pkg::ActPopBack, deq_pkg::ActPeekBack: begin
          if (empty) begin
            rsp_d.status = deq_pkg::StsEmpty;
          end else begin
            req.rd_en    = 1'b1;
            req.addr     = last_idx;
            rsp_d.rd_sel = 1'b1;
            if (item_i.action == deq_pkg::ActPopBack) begin
              count_d = count_q - deq_pkg::CntW'(1);
            end
          end
        end
        deq_pkg::ActClear: begin
          head_d  = '0;
          count_d = '0;
        end
        default: begin
          // unused action code: no change
        end
      endcase
    end
  end

  // hold pointer state and the pending result
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q  <= '0;
      count_q <= '0;
      rsp_q   <= '0;
    end else begin
      head_q  <= head_d;
      count_q <= count_d;
      rsp_q   <= rsp_d;
    end
  end

  assign mem_req_o = req;
  assign rsp_o     = rsp_q;

endmodule

/* hw/rtl/double_ended_queue.sv */
// Double-ended queue top level: control unit plus entry RAM.
// Uses deq_pkg, deq_ctrl and deq_ram.
//
// A word is taken at every clock edge where start is high; busy is never
// raised, so one word per cycle is sustained. Each word gives exactly one
// result on result_o, marked by done_o for one cycle, on the cycle right
// after it was taken; status and RAM read data are both registered. Results
// cannot be held off. The queue holds Depth words; pushes into a full
// queue report full, pops and peeks on an empty one report empty with zero
// data. The RAM is not cleared: clear only resets the head and count.
module double_ended_queue (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start,
  output logic               busy,
  input  deq_pkg::deq_in_t   item_i,
  output logic               done_o,
  output deq_pkg::deq_out_t  result_o
);

  deq_pkg::deq_mem_req_t     mem_req;
  deq_pkg::deq_rsp_t         rsp;
  logic [deq_pkg::DataW-1:0] rdata;
  logic                      accept;

  assign busy   = 1'b0;
  assign accept = start & ~busy;

  deq_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .accept_i  (accept),
    .item_i    (item_i),
    .mem_req_o (mem_req),
    .rsp_o     (rsp)
  );

  deq_ram #(
    .Depth (deq_pkg::Depth),
    .Width (deq_pkg::DataW)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (mem_req.wr_en),
    .re_i    (mem_req.rd_en),
    .addr_i  (mem_req.addr),
    .wdata_i (mem_req.wdata),
    .rdata_o (rdata)
  );

  // zero the data word unless a pop or peek succeeded
  assign done_o             = rsp.valid;
  assign result_o.status    = rsp.status;
  assign result_o.read_data = rsp.rd_sel ? deq_pkg::ItemW'(rdata) : '0;

endmodule

/* hw/rtl/deq_checker.sv */
// Port-level checker for the double-ended queue, bound to the top level.
// Uses deq_pkg and double_ended_queue_defines.svh.
`include "double_ended_queue_defines.svh"

module deq_checker (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               start,
  input logic               busy,
  input deq_pkg::deq_in_t   item_i,
  input logic               done_o,
  input deq_pkg::deq_out_t  result_o
);

  logic acc;
  assign acc = start & ~busy;

  `DEQ_ASSERT_NEXT(a_result_follows, acc, done_o, "accepted word gave no result")
  `DEQ_ASSERT(a_no_spurious, done_o |-> $past(acc), "result without accepted word")
  `DEQ_ASSERT(a_err_zero, (done_o && result_o.status != deq_pkg::StsOk) |-> (result_o.read_data == '0), "error result carries data")
  `DEQ_ASSERT(a_clear_empty, (acc && item_i.action == deq_pkg::ActClear) ##1 (acc && item_i.action == deq_pkg::ActPeekFront) |=> (done_o && result_o.status == deq_pkg::StsEmpty), "peek after clear not empty")
  `DEQ_ASSERT(a_push_pop, (acc && item_i.action == deq_pkg::ActPushFront) ##1 (acc && item_i.action == deq_pkg::ActPopFront && result_o.status == deq_pkg::StsOk) |=> (result_o.read_data == $past(item_i.push_data, 2)), "pop front lost pushed word")

endmodule

bind double_ended_queue deq_checker u_deq_checker (.*);
